@@ rtl/core/kce_pkg.sv @@
`timescale 1ns / 1ps
package kce_pkg;

   // length of the entered code in digits
   localparam int CODE_DIGITS = 4;
   localparam int CODE_BITS   = CODE_DIGITS * 4;
   localparam int REG_BITS    = 16;
   localparam int CMP_BITS    = (CODE_BITS > REG_BITS) ? CODE_BITS : REG_BITS;
   localparam int COUNT_BITS  = $clog2(CODE_DIGITS + 1);

   localparam int KEY_BITS    = 8;
   localparam int TIME_BITS   = 32;
   localparam int SOURCE_BITS = 8;
   localparam int DEB_BITS    = 8;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef logic [KEY_BITS-1:0]      key_type;
   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [3:0]               digit_type;
   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;

   // key codes
   localparam key_type KEY_STAR  = 8'h2A;
   localparam key_type KEY_HASH  = 8'h23;
   localparam key_type KEY_ZERO  = 8'h30;
   localparam key_type KEY_NINE  = 8'h39;

   // register indexes
   localparam csr_addr_type REG_ARM_CODE    = 2'd0;
   localparam csr_addr_type REG_DISARM_CODE = 2'd1;
   localparam csr_addr_type REG_SOURCE_ID   = 2'd2;
   localparam csr_addr_type REG_DEBOUNCE_MS = 2'd3;

   // reset values
   localparam logic [REG_BITS-1:0]    ARM_CODE_RESET    = 16'h1234;
   localparam logic [REG_BITS-1:0]    DISARM_CODE_RESET = 16'h0000;
   localparam logic [SOURCE_BITS-1:0] SOURCE_ID_RESET   = 8'd0;
   localparam logic [DEB_BITS-1:0]    DEBOUNCE_RESET    = 8'd30;

   // event kinds
   localparam logic EVENT_ARM    = 1'b0;
   localparam logic EVENT_DISARM = 1'b1;

endpackage

@@ rtl/core/keypad_code_entry_unit.sv @@
`timescale 1ns / 1ps
// Keypad code entry: takes one key item per cycle (ASCII code plus millisecond
// timestamp) and emits an arm or disarm event when '#' follows a full entry
// of CODE_DIGITS digits (further digits are dropped) that matches the arm code
// (checked first) or the disarm code. Keys closer than debounce_ms to the last
// accepted key are ignored, '*' clears the entry. From acceptance an item passes
// through the input register and then the decode and compare logic that writes
// the result register; the block accepts one item every cycle while the result
// side is not stalled. Registers are written by index on the csr port and
// should only change while no key is in flight.
module keypad_code_entry_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] key_char, [39:8] now_ms
   input  logic [kce_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] event_time, [39:32] event_source
   output logic [kce_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // [0] event_kind
   output logic [0:0]                            rsp_tuser,
   input  logic                                  csr_we,
   input  logic [kce_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [kce_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   // configuration
   logic [kce_pkg::REG_BITS-1:0]    arm_code_ff;
   logic [kce_pkg::REG_BITS-1:0]    disarm_code_ff;
   logic [kce_pkg::SOURCE_BITS-1:0] source_id_ff;
   logic [kce_pkg::DEB_BITS-1:0]    debounce_ff;

   // input register
   logic                  in_valid_ff;
   kce_pkg::key_type      in_key_ff;
   kce_pkg::time_type     in_now_ff;

   // entry state
   kce_pkg::digit_type    digit_ff [kce_pkg::CODE_DIGITS];
   kce_pkg::count_type    count_ff;
   kce_pkg::count_type    count_in;
   kce_pkg::time_type     last_time_ff;
   kce_pkg::time_type     last_time_in;

   // result register
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic                            out_kind_ff;
   logic                            out_kind_in;
   kce_pkg::time_type               out_time_ff;
   logic [kce_pkg::SOURCE_BITS-1:0] out_source_ff;

   logic                            advance;
   logic                            key_taken;
   logic                            is_digit;
   logic [kce_pkg::CODE_BITS-1:0]   entered;
   logic [kce_pkg::CMP_BITS-1:0]    entered_ext;
   logic [kce_pkg::CMP_BITS-1:0]    arm_ext;
   logic [kce_pkg::CMP_BITS-1:0]    disarm_ext;
   kce_pkg::time_type               elapsed;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_code_ff    <= kce_pkg::ARM_CODE_RESET;
         disarm_code_ff <= kce_pkg::DISARM_CODE_RESET;
         source_id_ff   <= kce_pkg::SOURCE_ID_RESET;
         debounce_ff    <= kce_pkg::DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            kce_pkg::REG_ARM_CODE:    arm_code_ff    <= csr_wdata;
            kce_pkg::REG_DISARM_CODE: disarm_code_ff <= csr_wdata;
            kce_pkg::REG_SOURCE_ID:   source_id_ff   <= csr_wdata[kce_pkg::SOURCE_BITS-1:0];
            kce_pkg::REG_DEBOUNCE_MS: debounce_ff    <= csr_wdata[kce_pkg::DEB_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_key_ff <= req_tdata[kce_pkg::KEY_BITS-1:0];
         in_now_ff <= req_tdata[kce_pkg::KEY_BITS +: kce_pkg::TIME_BITS];
      end
   end

   always_comb begin
      for (int i = 0; i < kce_pkg::CODE_DIGITS; i++) begin
         entered[kce_pkg::CODE_BITS-1-4*i -: 4] = digit_ff[i];
      end
   end

   assign entered_ext = kce_pkg::CMP_BITS'(entered);
   assign arm_ext     = kce_pkg::CMP_BITS'(arm_code_ff);
   assign disarm_ext  = kce_pkg::CMP_BITS'(disarm_code_ff);

   assign elapsed   = in_now_ff - last_time_ff;
   assign key_taken = advance && (elapsed >= kce_pkg::TIME_BITS'(debounce_ff));
   assign is_digit  = in_key_ff inside {[kce_pkg::KEY_ZERO:kce_pkg::KEY_NINE]};

   always_comb begin
      count_in     = count_ff;
      last_time_in = last_time_ff;
      out_kind_in  = kce_pkg::EVENT_ARM;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (key_taken) begin
         last_time_in = in_now_ff;
         if (in_key_ff == kce_pkg::KEY_STAR) begin
            count_in = '0;
         end else if (is_digit) begin
            if (count_ff < kce_pkg::COUNT_BITS'(kce_pkg::CODE_DIGITS)) begin
               count_in = count_ff + 1'b1;
            end
         end else if (in_key_ff == kce_pkg::KEY_HASH) begin
            count_in = '0;
            if (count_ff == kce_pkg::COUNT_BITS'(kce_pkg::CODE_DIGITS)) begin
               if (entered_ext == arm_ext) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = kce_pkg::EVENT_ARM;
               end else if (entered_ext == disarm_ext) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = kce_pkg::EVENT_DISARM;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_time_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // digit store, written at the slot the count points to
   always_ff @(posedge clock) begin
      for (int i = 0; i < kce_pkg::CODE_DIGITS; i++) begin
         if (key_taken && is_digit && count_ff == kce_pkg::COUNT_BITS'(i)) begin
            digit_ff[i] <= in_key_ff[3:0];
         end
      end
   end

   // result payload loads only when a fresh event is produced
   always_ff @(posedge clock) begin
      if (out_valid_in && !(out_valid_ff && !rsp_tready)) begin
         out_kind_ff   <= out_kind_in;
         out_time_ff   <= in_now_ff;
         out_source_ff <= source_id_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_source_ff, out_time_ff};
   assign rsp_tuser  = out_kind_ff;

endmodule

@@ rtl/core/kce_checker.sv @@
`timescale 1ns / 1ps
module kce_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [kce_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input logic [0:0]                            rsp_tuser
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // reset leaves no result pending and the input open
   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   // with the result side empty the input never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // a fresh result needs the input side to have been ready the cycle before
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |=> !rsp_tvalid || $past(req_tready))
      else $error("result appeared without input progress");

endmodule

bind keypad_code_entry_unit kce_checker u_kce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/keypad_code_entry_checker.sv @@
`timescale 1ns / 1ps
module keypad_code_entry_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // [7:0] key_char, [39:8] now_ms
   input  logic [kce_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] event_time, [39:32] event_source
   input  logic [kce_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] event_kind
   input  logic [0:0]                        rsp_tuser,
   input  logic                              csr_we,
   input  logic [kce_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [kce_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                mismatches,
   output int                                events_due
);
   import kce_pkg::*;

   typedef struct packed {
      logic                   kind;
      time_type               stamp;
      logic [SOURCE_BITS-1:0] source;
   } alarm_event_type;

   digit_type              entry [CODE_DIGITS];
   count_type              held;
   time_type               last_accept;
   logic [REG_BITS-1:0]    arm_code;
   logic [REG_BITS-1:0]    disarm_code;
   logic [SOURCE_BITS-1:0] source_id;
   logic [DEB_BITS-1:0]    debounce;
   alarm_event_type        pending_alarms [$];

   task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
      if (mismatches < 10) begin
         $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
      end
      mismatches++;
   endtask

   // works out what one accepted key does to the entry and queues any event
   task automatic decode_key(input key_type key, input time_type now);
      time_type            elapsed;
      logic [CMP_BITS-1:0] entered;
      alarm_event_type     ev;
      elapsed = now - last_accept;
      if (elapsed < time_type'(debounce)) return;
      last_accept = now;
      if (key == KEY_STAR) begin
         held = '0;
      end else if (key >= KEY_ZERO && key <= KEY_NINE) begin
         if (held < CODE_DIGITS) begin
            entry[held] = digit_type'(key - KEY_ZERO);
            held = held + 1'b1;
         end
      end else if (key == KEY_HASH) begin
         if (held == CODE_DIGITS) begin
            entered = '0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
               entered = (entered << 4) | CMP_BITS'(entry[i]);
            end
            ev.stamp  = now;
            ev.source = source_id;
            // arm code is checked first, so it wins when both are equal
            if (entered == CMP_BITS'(arm_code)) begin
               ev.kind = EVENT_ARM;
               pending_alarms.push_back(ev);
            end else if (entered == CMP_BITS'(disarm_code)) begin
               ev.kind = EVENT_DISARM;
               pending_alarms.push_back(ev);
            end
         end
         held = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      alarm_event_type want;
      if (reset) begin
         held        = '0;
         last_accept = '0;
         arm_code    = ARM_CODE_RESET;
         disarm_code = DISARM_CODE_RESET;
         source_id   = SOURCE_ID_RESET;
         debounce    = DEBOUNCE_RESET;
         mismatches  = 0;
         for (int i = 0; i < CODE_DIGITS; i++) entry[i] = '0;
         pending_alarms.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_alarms.size() == 0) begin
               flag("unexpected event, time", '0, rsp_tdata[31:0]);
            end else begin
               want = pending_alarms.pop_front();
               if (rsp_tuser[0] !== want.kind) begin
                  flag("event_kind", 32'(want.kind), 32'(rsp_tuser[0]));
               end
               if (rsp_tdata[31:0] !== want.stamp) flag("event_time", want.stamp, rsp_tdata[31:0]);
               if (rsp_tdata[39:32] !== want.source) begin
                  flag("event_source", 32'(want.source), 32'(rsp_tdata[39:32]));
               end
            end
         end
         if (req_tvalid && req_tready) decode_key(req_tdata[7:0], req_tdata[39:8]);
         if (csr_we) begin
            case (csr_addr)
               REG_ARM_CODE:    arm_code    = csr_wdata[REG_BITS-1:0];
               REG_DISARM_CODE: disarm_code = csr_wdata[REG_BITS-1:0];
               REG_SOURCE_ID:   source_id   = csr_wdata[SOURCE_BITS-1:0];
               REG_DEBOUNCE_MS: debounce    = csr_wdata[DEB_BITS-1:0];
               default: ;
            endcase
         end
      end
      events_due <= pending_alarms.size();
   end

endmodule

@@ dv/tb_keypad_code_entry_unit.sv @@
`timescale 1ns / 1ps
module tb_keypad_code_entry_unit;
   import kce_pkg::*;

   localparam int ITEM_TOTAL   = 1050;
   localparam int PHASE_ITEMS  = 170;
   localparam int PHASES       = 6;
   localparam int CALM_ITEMS   = 120;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4;
   localparam int STUCK_LIMIT  = 2000;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;
   logic                     csr_we;
   csr_addr_type             csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int                  mismatches;
   int                  events_due;
   logic                calm          = 1'b0;
   logic                hold_request  = 1'b0;
   time_type            now_ms;
   logic [DEB_BITS-1:0] debounce_copy;
   logic [REG_BITS-1:0] arm_set;
   logic [REG_BITS-1:0] disarm_set;
   int                  keys_sent;
   int                  stuck_cycles;

   keypad_code_entry_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   keypad_code_entry_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .events_due (events_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic key_type digit_key(input int value);
      return key_type'(KEY_ZERO + value);
   endfunction

   function automatic logic [REG_BITS-1:0] random_bcd();
      logic [REG_BITS-1:0] code;
      for (int i = 0; i < 4; i++) code[4*i +: 4] = 4'($urandom_range(0, 9));
      return code;
   endfunction

   // mostly clear of the debounce window, sometimes inside it or a wild jump
   function automatic time_type next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 86) return debounce_copy + $urandom_range(0, 40);
      if (pick < 93) return $urandom_range(0, debounce_copy);
      if (pick < 97) return time_type'(debounce_copy);
      return $urandom();
   endfunction

   task automatic press(input key_type key, input time_type delta);
      now_ms = now_ms + delta;
      if (!calm && (keys_sent / 64) % 3 != 2 && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now_ms, key};
      do @(posedge clock); while (!req_tready);
      keys_sent++;
      if (keys_sent >= ITEM_TOTAL - CALM_ITEMS) calm = 1'b1;
   endtask

   // items that raise no event may still be in the pipe when the last event lands
   task automatic wait_idle();
      @(posedge clock);
      while (events_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [REG_BITS-1:0] arm, input logic [REG_BITS-1:0] dis,
                             input logic [SOURCE_BITS-1:0] src, input logic [DEB_BITS-1:0] deb);
      logic [7:0] pad;
      req_tvalid <= 1'b0;
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= REG_ARM_CODE;
      csr_wdata <= arm;
      @(posedge clock);
      csr_addr  <= REG_DISARM_CODE;
      csr_wdata <= dis;
      @(posedge clock);
      pad = 8'($urandom_range(0, 255));
      csr_addr  <= REG_SOURCE_ID;
      csr_wdata <= {pad, src};
      @(posedge clock);
      pad = 8'($urandom_range(0, 255));
      csr_addr  <= REG_DEBOUNCE_MS;
      csr_wdata <= {pad, deb};
      @(posedge clock);
      csr_we <= 1'b0;
      arm_set       = arm;
      disarm_set    = dis;
      debounce_copy = deb;
   endtask

   task automatic random_entry();
      logic [REG_BITS-1:0] code;
      int                  pick;
      int                  n;
      digit_type           nib;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         n = $urandom_range(0, 99);
         code = (n < 50) ? arm_set : (n < 85) ? disarm_set : random_bcd();
         // first digit typed goes to the top nibble
         for (int i = 3; i >= 0; i--) begin
            nib = code[4*i +: 4];
            if (nib > 9) nib = digit_type'($urandom_range(0, 9));
            press(digit_key(int'(nib)), next_gap());
         end
         press(KEY_HASH, next_gap());
      end else if (pick < 82) begin
         n = $urandom_range(0, 7);
         repeat (n) press(digit_key($urandom_range(0, 9)), next_gap());
         press(KEY_HASH, next_gap());
      end else if (pick < 88) begin
         press(KEY_STAR, next_gap());
      end else begin
         press(key_type'($urandom_range(0, 255)), next_gap());
      end
   endtask

   initial begin : result_sink
      int cycles;
      cycles = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cycles++;
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && (cycles / 200) % 4 != 3 && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("** keypad_code_entry_unit: FAILED **");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [REG_BITS-1:0]    arm;
      logic [REG_BITS-1:0]    dis;
      logic [SOURCE_BITS-1:0] src;
      logic [DEB_BITS-1:0]    deb;
      int                     phase_end;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_ARM_CODE;
      csr_wdata  <= '0;
      now_ms        = '0;
      keys_sent     = 0;
      arm_set       = ARM_CODE_RESET;
      disarm_set    = DISARM_CODE_RESET;
      debounce_copy = DEBOUNCE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: arm 1234, disarm 0000, debounce 30
      press(digit_key(5), 10);               // inside the window after reset
      press(digit_key(1), 40);
      press(digit_key(2), 40);
      press(digit_key(3), 40);
      press(digit_key(4), 40);
      press(KEY_HASH, 40);
      press(digit_key(1), 40);
      press(digit_key(2), 40);
      press(digit_key(3), 40);
      press(digit_key(4), 40);
      press(digit_key(9), 40);               // fifth digit dropped
      press(KEY_HASH, 40);
      press(digit_key(1), 40);
      press(digit_key(2), 29);               // bounced
      press(KEY_HASH, 30);                   // short entry, no event
      press(digit_key(7), 30);               // exactly on the debounce edge
      press(KEY_STAR, 40);
      press(KEY_HASH, 40);
      press(8'hFF, 40);
      press(8'h00, 40);
      press(key_type'(KEY_ZERO - 1), 40);
      press(key_type'(KEY_NINE + 1), 40);
      press(digit_key(0), 32'hFFFF_FFF0 - now_ms);
      press(digit_key(0), 32);               // timestamp wraps past zero
      press(digit_key(0), 40);
      press(digit_key(0), 40);
      press(KEY_HASH, 40);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               arm = 16'h0000; dis = 16'h9999; src = 8'hFF; deb = 8'd0;
            end
            1: begin
               arm = 16'hFFFF; dis = random_bcd(); src = 8'h00; deb = 8'd255;
            end
            2: begin
               arm = random_bcd(); dis = arm; src = 8'($urandom_range(0, 255));
               deb = 8'($urandom_range(1, 60));
            end
            3: begin
               arm = random_bcd(); dis = 16'h9999; src = 8'hA5; deb = 8'd1;
            end
            4: begin
               arm = 16'($urandom_range(0, 65535)); dis = random_bcd();
               src = 8'($urandom_range(0, 255)); deb = 8'($urandom_range(0, 255));
            end
            default: begin
               arm = random_bcd(); dis = random_bcd(); src = 8'($urandom_range(0, 255));
               deb = DEBOUNCE_RESET;
            end
         endcase
         write_regs(arm, dis, src, deb);
         // long result stall while keys keep coming, so the input backs up
         if (phase == 2) hold_request = 1'b1;
         phase_end = keys_sent + PHASE_ITEMS;
         while (keys_sent < phase_end) random_entry();
      end

      req_tvalid <= 1'b0;
      wait_idle();
      if (mismatches == 0) begin
         $display("** keypad_code_entry_unit: PASSED **");
      end else begin
         $display("** keypad_code_entry_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/kce_pkg.sv
rtl/core/keypad_code_entry_unit.sv
rtl/core/kce_checker.sv
dv/keypad_code_entry_checker.sv
dv/tb_keypad_code_entry_unit.sv
